[rtl/modinv_pkg.sv]
// shared types, constants and the control program of the modular inverse sequencer
// no dependencies; imported by modular_inverse
package modinv_pkg;

   localparam int unsigned VALUE_W = 32;   // req value field
   localparam int unsigned INV_W   = 32;   // rsp inverse field
   localparam int unsigned CSR_W   = 32;   // register data
   localparam int unsigned ADDR_W  = 3;    // byte address of the register file
   localparam int unsigned PC_W    = 4;

   // register index, taken from csr_paddr[2]
   localparam logic REG_MODULUS = 1'b0;

   typedef logic [PC_W-1:0] pc_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_DIV_LOAD_A,   // divider takes value / modulus
      OP_DIV_LOAD_R,   // divider takes r0 / r1
      OP_DIV_RUN,      // one quotient bit a cycle
      OP_INIT,
      OP_QRED,         // reduce quotient, load multiplier
      OP_MUL_RUN,      // one multiplier bit a cycle
      OP_UPDATE,
      OP_EMIT,
      OP_EMIT_NONE
   } op_type;

   typedef enum logic [1:0] {
      C_NEVER,
      C_ALWAYS,
      C_M_ZERO,
      C_R1_ZERO
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } ucode_type;

   localparam pc_type ST_LOOP = pc_type'(4);
   localparam pc_type ST_DONE = pc_type'(10);
   localparam pc_type ST_NONE = pc_type'(11);

   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      w = '{op: OP_EMIT_NONE, cond: C_NEVER, target: '0};
      unique case (pc)
         pc_type'(0):  w = '{op: OP_NOP,        cond: C_M_ZERO,  target: ST_NONE};
         pc_type'(1):  w = '{op: OP_DIV_LOAD_A, cond: C_NEVER,   target: '0};
         pc_type'(2):  w = '{op: OP_DIV_RUN,    cond: C_NEVER,   target: '0};
         pc_type'(3):  w = '{op: OP_INIT,       cond: C_NEVER,   target: '0};
         pc_type'(4):  w = '{op: OP_NOP,        cond: C_R1_ZERO, target: ST_DONE};
         pc_type'(5):  w = '{op: OP_DIV_LOAD_R, cond: C_NEVER,   target: '0};
         pc_type'(6):  w = '{op: OP_DIV_RUN,    cond: C_NEVER,   target: '0};
         pc_type'(7):  w = '{op: OP_QRED,       cond: C_NEVER,   target: '0};
         pc_type'(8):  w = '{op: OP_MUL_RUN,    cond: C_NEVER,   target: '0};
         pc_type'(9):  w = '{op: OP_UPDATE,     cond: C_ALWAYS,  target: ST_LOOP};
         pc_type'(10): w = '{op: OP_EMIT,       cond: C_NEVER,   target: '0};
         default:      w = '{op: OP_EMIT_NONE,  cond: C_NEVER,   target: '0};
      endcase
      return w;
   endfunction

endpackage

[rtl/modular_inverse.sv]
// modular inverse by the extended euclidean algorithm, microcoded sequencer
// depends on modinv_pkg (types, control program)
//
// usage:
//  - req channel: one 32-bit value per transaction; the block takes a new
//    transaction only when the previous one has left the sequencer.
//  - rsp channel: tdata carries the inverse in 0..modulus-1 (zero when none
//    exists), tuser carries the found flag. one rsp transaction per req.
//  - csr port: register 0 (byte address 0) is the modulus, reset value 1.
//    write it only while no req transaction is in flight.
//  - the divider and the shift-add modular multiplier each give one bit a
//    cycle; an item runs one division, then one division and one
//    multiplication for each euclid step.
//  - a finished result waits in the rsp register; the next req transaction
//    is taken meanwhile, and the sequencer holds at its final step only if
//    the previous result has still not been taken.
//  - reset clears the sequencer and the rsp valid and sets the modulus to 1.
module modular_inverse #(
   parameter int unsigned WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // req: value [31:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [modinv_pkg::VALUE_W-1:0]      req_tdata,
   // rsp tdata: inverse [31:0]; tuser: found [0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [modinv_pkg::INV_W-1:0]        rsp_tdata,
   output logic                                rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [modinv_pkg::ADDR_W-1:0]       csr_paddr,
   input  logic [modinv_pkg::CSR_W-1:0]        csr_pwdata,
   output logic [modinv_pkg::CSR_W-1:0]        csr_prdata,
   output logic                                csr_pready
);
   import modinv_pkg::*;

   localparam int unsigned DW = (WIDTH < VALUE_W) ? WIDTH : VALUE_W;
   localparam int unsigned CW = $clog2(DW);
   localparam logic [CW-1:0] LAST_BIT = CW'(DW - 1);

   function automatic logic [DW-1:0] add_mod(input logic [DW-1:0] x,
                                             input logic [DW-1:0] y,
                                             input logic [DW-1:0] m);
      logic [DW-1:0] gap;
      gap = m - y;
      return (x >= gap) ? (x - gap) : (x + y);
   endfunction

   function automatic logic [DW-1:0] sub_mod(input logic [DW-1:0] x,
                                             input logic [DW-1:0] y,
                                             input logic [DW-1:0] m);
      return (x >= y) ? (x - y) : (m - y + x);
   endfunction

   // control
   logic            busy_ff, busy_in;
   pc_type          pc_ff, pc_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            rsp_tvalid_ff, rsp_tvalid_in;
   logic [CSR_W-1:0] mod_ff, mod_in;

   // datapath
   logic [DW-1:0]   a_ff, a_in;
   logic [DW-1:0]   r0_ff, r0_in, r1_ff, r1_in;
   logic [DW-1:0]   t0_ff, t0_in, t1_ff, t1_in;
   logic [DW-1:0]   quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DW-1:0]   mx_ff, mx_in, my_ff, my_in, acc_ff, acc_in;
   logic [INV_W-1:0] rsp_inv_ff, rsp_inv_in;
   logic            rsp_found_ff, rsp_found_in;

   ucode_type       uw;
   logic [DW-1:0]   m;
   logic [DW:0]     div_shift;
   logic            div_ge;
   logic            cond_hit;
   logic            step_done;
   logic            out_free;
   logic            req_take;
   logic            csr_write;

   assign m          = mod_ff[DW-1:0];
   assign uw         = ucode_rom(pc_ff);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = !busy_ff;
   assign req_take   = req_tvalid && !busy_ff;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   assign div_shift  = {rem_ff, quo_ff[DW-1]};
   assign div_ge     = div_shift >= {1'b0, dvs_ff};

   always_comb begin
      case (uw.cond)
         C_ALWAYS:  cond_hit = 1'b1;
         C_M_ZERO:  cond_hit = (m == '0);
         C_R1_ZERO: cond_hit = (r1_ff == '0);
         default:   cond_hit = 1'b0;
      endcase
   end

   always_comb begin
      unique case (uw.op)
         OP_DIV_RUN, OP_MUL_RUN:  step_done = (cnt_ff == LAST_BIT);
         OP_EMIT, OP_EMIT_NONE:   step_done = out_free;
         default:                 step_done = 1'b1;
      endcase
   end

   // sequencer and register file
   always_comb begin
      busy_in       = busy_ff;
      pc_in         = pc_ff;
      cnt_in        = cnt_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      mod_in        = mod_ff;

      if (csr_write && csr_paddr[2] == REG_MODULUS) begin
         mod_in = csr_pwdata;
      end

      if (!busy_ff) begin
         if (req_take) begin
            busy_in = 1'b1;
            pc_in   = '0;
         end
      end else begin
         if (uw.op == OP_DIV_RUN || uw.op == OP_MUL_RUN) begin
            cnt_in = cnt_ff + 1'b1;
         end else begin
            cnt_in = '0;
         end
         if (step_done) begin
            pc_in = cond_hit ? uw.target : pc_ff + 1'b1;
            if (uw.op == OP_EMIT || uw.op == OP_EMIT_NONE) begin
               busy_in       = 1'b0;
               pc_in         = '0;
               rsp_tvalid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pc_ff         <= '0;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
         mod_ff        <= CSR_W'(1);
      end else begin
         busy_ff       <= busy_in;
         pc_ff         <= pc_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         mod_ff        <= mod_in;
      end
   end

   // datapath driven by the current control word
   always_comb begin
      a_in         = a_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      acc_in       = acc_ff;
      rsp_inv_in   = rsp_inv_ff;
      rsp_found_in = rsp_found_ff;

      if (req_take) begin
         a_in = req_tdata[DW-1:0];
      end

      if (busy_ff) begin
         unique case (uw.op)
            OP_DIV_LOAD_A: begin
               quo_in = a_ff;
               rem_in = '0;
               dvs_in = m;
            end
            OP_DIV_LOAD_R: begin
               quo_in = r0_ff;
               rem_in = '0;
               dvs_in = r1_ff;
            end
            OP_DIV_RUN: begin
               rem_in = div_ge ? DW'(div_shift - {1'b0, dvs_ff}) : div_shift[DW-1:0];
               quo_in = {quo_ff[DW-2:0], div_ge};
            end
            OP_INIT: begin
               r0_in = m;
               r1_in = rem_ff;
               t0_in = '0;
               t1_in = {{(DW-1){1'b0}}, (m != DW'(1))};
            end
            OP_QRED: begin
               // quotient is at most the modulus, so one subtract reduces it
               mx_in  = (quo_ff >= m) ? (quo_ff - m) : quo_ff;
               my_in  = t1_ff;
               acc_in = '0;
            end
            OP_MUL_RUN: begin
               acc_in = my_ff[0] ? add_mod(acc_ff, mx_ff, m) : acc_ff;
               mx_in  = add_mod(mx_ff, mx_ff, m);
               my_in  = my_ff >> 1;
            end
            OP_UPDATE: begin
               t1_in = sub_mod(t0_ff, acc_ff, m);
               t0_in = t1_ff;
               r0_in = r1_ff;
               r1_in = rem_ff;
            end
            OP_EMIT: begin
               if (out_free) begin
                  rsp_found_in = (r0_ff == DW'(1));
                  rsp_inv_in   = (r0_ff == DW'(1)) ? INV_W'(t0_ff) : '0;
               end
            end
            OP_EMIT_NONE: begin
               if (out_free) begin
                  rsp_found_in = 1'b0;
                  rsp_inv_in   = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      r0_ff        <= r0_in;
      r1_ff        <= r1_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      mx_ff        <= mx_in;
      my_ff        <= my_in;
      acc_ff       <= acc_in;
      rsp_inv_ff   <= rsp_inv_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_inv_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MODULUS) ? mod_ff : '0;

`ifndef SYNTHESIS
   // an accepted transaction starts the program at its first step
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (busy_ff && pc_ff == '0))
      else $error("sequencer did not start on accepted transaction");

   // the divider never runs against a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && uw.op == OP_DIV_RUN) |-> (dvs_ff != '0))
      else $error("divide by zero in sequencer");

   // no inverse means a zero result
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("nonzero inverse without found");

   // a found inverse lies below the modulus
   a_inv_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata < mod_ff))
      else $error("inverse not reduced");

   // the multiplier operands stay reduced
   a_mul_reduced: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && uw.op == OP_MUL_RUN) |-> (mx_ff < m && acc_ff < m))
      else $error("multiplier operand out of range");
`endif

endmodule
